// ===== hdl/lobm_pkg.sv =====
// ----------------------------------------------------------------------------
// lobm_pkg: shared types and constants of the order book matcher
// controller states, command and status bundles, modulus
// ----------------------------------------------------------------------------
`default_nettype none

package lobm_pkg;

  localparam int unsigned DefaultBookDepth = 64;
  localparam logic [31:0] Modulus = 32'd1000000007;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MRD,
    S_MCHK,
    S_FMOD,
    S_FSUB,
    S_ISTART,
    S_IRD,
    S_ICHK,
    S_RLOAD,
    S_RSUB,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic rd_head;
    logic trade;
    logic acc_filled;
    logic acc_rem;
    logic acc_sub;
    logic total_sub;
    logic total_add;
    logic ins_check;
    logic ins_rd;
    logic ins_shift;
    logic ins_place;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic rem_zero;
    logic opp_empty;
    logic crosses;
    logic own_full;
    logic idx_zero;
    logic better;
    logic acc_ge;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/lobm_ctrl.sv =====
// ----------------------------------------------------------------------------
// lobm_ctrl: order sequencer
// walks match, backlog update and sorted insertion for one item
// ----------------------------------------------------------------------------
`default_nettype none

module lobm_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire lobm_pkg::status_t sts_i,
  output lobm_pkg::cmd_t        cmd_o
);

  lobm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lobm_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      lobm_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = lobm_pkg::S_MRD;
        end
      end
      lobm_pkg::S_MRD: begin
        if (sts_i.rem_zero || sts_i.opp_empty) begin
          state_d = lobm_pkg::S_FMOD;
        end else begin
          cmd_o.rd_head = 1'b1;
          state_d       = lobm_pkg::S_MCHK;
        end
      end
      lobm_pkg::S_MCHK: begin
        if (sts_i.crosses) begin
          cmd_o.trade = 1'b1;
          state_d     = lobm_pkg::S_MRD;
        end else begin
          state_d = lobm_pkg::S_FMOD;
        end
      end
      lobm_pkg::S_FMOD: begin
        cmd_o.acc_filled = 1'b1;
        state_d          = lobm_pkg::S_FSUB;
      end
      lobm_pkg::S_FSUB: begin
        if (sts_i.acc_ge) begin
          cmd_o.acc_sub = 1'b1;
        end else begin
          cmd_o.total_sub = 1'b1;
          state_d         = lobm_pkg::S_ISTART;
        end
      end
      lobm_pkg::S_ISTART: begin
        if (sts_i.rem_zero) begin
          state_d = lobm_pkg::S_DONE;
        end else begin
          cmd_o.ins_check = 1'b1;
          state_d = sts_i.own_full ? lobm_pkg::S_DONE : lobm_pkg::S_IRD;
        end
      end
      lobm_pkg::S_IRD: begin
        if (sts_i.idx_zero) begin
          cmd_o.ins_place = 1'b1;
          state_d         = lobm_pkg::S_RLOAD;
        end else begin
          cmd_o.ins_rd = 1'b1;
          state_d      = lobm_pkg::S_ICHK;
        end
      end
      lobm_pkg::S_ICHK: begin
        if (sts_i.better) begin
          cmd_o.ins_shift = 1'b1;
          state_d         = lobm_pkg::S_IRD;
        end else begin
          cmd_o.ins_place = 1'b1;
          state_d         = lobm_pkg::S_RLOAD;
        end
      end
      lobm_pkg::S_RLOAD: begin
        cmd_o.acc_rem = 1'b1;
        state_d       = lobm_pkg::S_RSUB;
      end
      lobm_pkg::S_RSUB: begin
        if (sts_i.acc_ge) begin
          cmd_o.acc_sub = 1'b1;
        end else begin
          cmd_o.total_add = 1'b1;
          state_d         = lobm_pkg::S_DONE;
        end
      end
      lobm_pkg::S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = lobm_pkg::S_IDLE;
        end
      end
      default: state_d = lobm_pkg::S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != lobm_pkg::S_IDLE);

endmodule

`default_nettype wire

// ===== hdl/lobm_dpath.sv =====
// ----------------------------------------------------------------------------
// lobm_dpath: book storage and arithmetic
// ring-buffer books in one memory, trade math, modular backlog, result register
// ----------------------------------------------------------------------------
`default_nettype none

module lobm_dpath #(
  parameter int unsigned BOOK_DEPTH = lobm_pkg::DefaultBookDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [31:0]       price_i,
  input  wire logic [31:0]       amount_i,
  input  wire logic              is_sell_i,
  input  wire lobm_pkg::cmd_t    cmd_i,
  output lobm_pkg::status_t      sts_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [29:0]            backlog_mod_o,
  output logic [31:0]            filled_volume_o,
  output logic                   remainder_dropped_o
);

  localparam int unsigned AW = $clog2(BOOK_DEPTH);
  localparam int unsigned CW = $clog2(BOOK_DEPTH + 1);
  localparam logic [CW:0] DepthW = (CW + 1)'(BOOK_DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(BOOK_DEPTH);

  // book storage, index 0 buy, 1 sell
  logic [63:0] mem_q [2][BOOK_DEPTH];
  logic [63:0] rdata_q;

  logic [AW-1:0] head_q [2];
  logic [CW-1:0] cnt_q  [2];
  logic [29:0]   total_q;
  logic [CW-1:0] idx_q;
  logic [31:0]   price_q, rem_q, filled_q, acc_q;
  logic          side_q, dropped_q;

  logic          own, opp;
  logic [31:0]   hp, ha, k;
  logic [63:0]   key;
  logic [AW-1:0] wr_addr, rd_addr, ins_wr, ins_rd, head_inc;
  logic          we, re, wside, rside;
  logic [63:0]   wdata;
  logic [30:0]   sum_add, sum_sub;

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] h, input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW + 1)'(h) + (CW + 1)'(off);
    if (s >= DepthW) s = s - DepthW;
    return s[AW-1:0];
  endfunction

  assign own = side_q;
  assign opp = ~side_q;
  assign hp  = rdata_q[63:32];
  assign ha  = rdata_q[31:0];
  assign k   = (ha < rem_q) ? ha : rem_q;
  assign key = {price_q, rem_q};

  assign ins_wr   = wrap(head_q[own], idx_q);
  assign ins_rd   = wrap(head_q[own], idx_q - CW'(1));
  assign head_inc = wrap(head_q[opp], CW'(1));

  always_comb begin
    sts_o.rem_zero  = (rem_q == '0);
    sts_o.opp_empty = (cnt_q[opp] == '0);
    sts_o.crosses   = side_q ? (hp >= price_q) : (hp <= price_q);
    sts_o.own_full  = (cnt_q[own] == DepthC);
    sts_o.idx_zero  = (idx_q == '0);
    sts_o.better    = side_q ? (key < rdata_q) : (key > rdata_q);
    sts_o.acc_ge    = (acc_q >= lobm_pkg::Modulus);
    sts_o.out_busy  = out_valid_o && out_stall_i;
  end

  // memory port control
  always_comb begin
    we      = 1'b0;
    wside   = own;
    wr_addr = ins_wr;
    wdata   = key;
    re      = cmd_i.rd_head || cmd_i.ins_rd;
    rside   = cmd_i.rd_head ? opp : own;
    rd_addr = cmd_i.rd_head ? head_q[opp] : ins_rd;
    if (cmd_i.trade && (ha != k)) begin
      we      = 1'b1;
      wside   = opp;
      wr_addr = head_q[opp];
      wdata   = {hp, ha - k};
    end else if (cmd_i.ins_shift) begin
      we    = 1'b1;
      wdata = rdata_q;
    end else if (cmd_i.ins_place) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wside][wr_addr] <= wdata;
    if (re) rdata_q <= mem_q[rside][rd_addr];
  end

  // modular backlog update, both operands below the modulus
  assign sum_add = {1'b0, total_q} + acc_q[30:0];
  assign sum_sub = (total_q >= acc_q[29:0]) ? ({1'b0, total_q} - acc_q[30:0])
                 : ({1'b0, total_q} + lobm_pkg::Modulus[30:0] - acc_q[30:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q[0] <= '0;
      head_q[1] <= '0;
      cnt_q[0]  <= '0;
      cnt_q[1]  <= '0;
      total_q   <= '0;
    end else begin
      if (cmd_i.trade && (ha == k)) begin
        head_q[opp] <= head_inc;
        cnt_q[opp]  <= cnt_q[opp] - CW'(1);
      end
      if (cmd_i.ins_place) cnt_q[own] <= cnt_q[own] + CW'(1);
      if (cmd_i.total_sub) total_q <= sum_sub[29:0];
      if (cmd_i.total_add) begin
        total_q <= (sum_add >= lobm_pkg::Modulus[30:0])
                 ? 30'(sum_add - lobm_pkg::Modulus[30:0]) : sum_add[29:0];
      end
    end
  end

  // per-item working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      price_q   <= price_i;
      rem_q     <= amount_i;
      side_q    <= is_sell_i;
      filled_q  <= '0;
      dropped_q <= 1'b0;
    end
    if (cmd_i.trade) begin
      rem_q    <= rem_q - k;
      filled_q <= filled_q + k;
    end
    if (cmd_i.acc_filled) acc_q <= filled_q;
    if (cmd_i.acc_rem)    acc_q <= rem_q;
    if (cmd_i.acc_sub)    acc_q <= acc_q - lobm_pkg::Modulus;
    if (cmd_i.ins_check) begin
      idx_q <= cnt_q[own];
      if (cnt_q[own] == DepthC) dropped_q <= 1'b1;
    end
    if (cmd_i.ins_shift) idx_q <= idx_q - CW'(1);
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      backlog_mod_o       <= total_q;
      filled_volume_o     <= filled_q;
      remainder_dropped_o <= dropped_q;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[0] <= DepthC) && (cnt_q[1] <= DepthC))
    else $error("book count above depth");

  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q < lobm_pkg::Modulus[29:0])
    else $error("backlog not reduced");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_o)
    else $error("result not presented");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_o && out_stall_i))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== hdl/limit_order_book_matcher.sv =====
// ----------------------------------------------------------------------------
// limit_order_book_matcher: price-time limit order book with matching
// buy and sell books, trade against the opposite head, sorted rest insert
// ----------------------------------------------------------------------------
//   channel | direction | handshake            | payload
//   in      | input     | in_valid_i/in_stall_o | price_i, amount_i, is_sell_i
//   out     | output    | out_valid_o/out_stall_i | backlog_mod_o, filled_volume_o,
//           |           |                      | remainder_dropped_o
//
// per item: load, then per trade a head read and a cross check, a modular reduction
//   of the filled volume (0..4 subtractions of the modulus) and the backlog subtract;
//   when the remainder rests and the own book is not full, a sorted insert reads and
//   compares entries from the back, shifting each one that the new entry outranks,
//   then places it, reduces the remainder and adds it to the backlog; the registered
//   read of the single book memory port splits each read and its check into a read and a check state
// reset clears counts, ring heads and the backlog; book entries are not cleared
// the next item is taken once the result sits in the output register
// a stalled result only holds back the following item at its final step
`default_nettype none

module limit_order_book_matcher #(
  parameter int unsigned BOOK_DEPTH = lobm_pkg::DefaultBookDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] price_i,
  input  wire logic [31:0] amount_i,
  input  wire logic        is_sell_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [29:0]      backlog_mod_o,
  output logic [31:0]      filled_volume_o,
  output logic             remainder_dropped_o
);

  // command and status between sequencer and datapath
  lobm_pkg::cmd_t    cmd;
  lobm_pkg::status_t sts;

  lobm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // books, trade arithmetic and the result register
  lobm_dpath #(
    .BOOK_DEPTH (BOOK_DEPTH)
  ) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .price_i             (price_i),
    .amount_i            (amount_i),
    .is_sell_i           (is_sell_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .backlog_mod_o       (backlog_mod_o),
    .filled_volume_o     (filled_volume_o),
    .remainder_dropped_o (remainder_dropped_o)
  );

endmodule

`default_nettype wire
